@@ hw/rtl/ball_pair_collision_response_top_assert.svh @@
// Assertion macros shared by the ball pair collision response block.
`ifndef BALL_PAIR_COLLISION_RESPONSE_TOP_ASSERT_SVH
`define BALL_PAIR_COLLISION_RESPONSE_TOP_ASSERT_SVH

// Condition implies property in the same cycle.
`define BPCR_ASSERT_SAME(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("bpcr assertion failed");

// Condition implies property in the next cycle.
`define BPCR_ASSERT_NEXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("bpcr assertion failed");

`endif

@@ hw/rtl/bpcr_pkg.sv @@
// Package: shared types, codes and constants of the ball pair collision block.
package bpcr_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int SQRT_STEPS    = 32;

  localparam logic [16:0] REBOUND_RESET = 17'd32768;
  localparam logic        REG_REBOUND   = 1'b0;

  localparam logic [1:0] ST_APART      = 2'd0;
  localparam logic [1:0] ST_FIXED      = 2'd1;
  localparam logic [1:0] ST_RESOLVED   = 2'd2;
  localparam logic [1:0] ST_COINCIDENT = 2'd3;

  typedef enum logic [3:0] {
    C_NONE, C_STORE_A, C_LOAD_B, C_MUL, C_CHECK, C_SQRT,
    C_DIV_INIT, C_DIV_STEP, C_DIV_STORE
  } cop_t;

  typedef enum logic [4:0] {
    M_SQ0, M_SQ1, M_SQ2, M_RSQ,
    M_KA, M_KB, M_VP0, M_VP1, M_VP2,
    M_SA, M_SB, M_WA, M_WB,
    M_DA0, M_DA1, M_DA2, M_DB0, M_DB1, M_DB2,
    M_VA0, M_VA1, M_VA2, M_VB0, M_VB1, M_VB2
  } mop_t;

  typedef enum logic [2:0] {
    D_N0, D_N1, D_N2, D_CA, D_CB
  } dsel_t;

  typedef struct packed {
    cop_t  op;
    mop_t  mop;
    dsel_t dsel;
    logic  show_b;
  } cmd_t;

  typedef struct packed {
    logic [1:0] outcome;
  } sts_t;

  function automatic logic [1:0] mop_axis(input mop_t m);
    case (m)
      M_SQ1, M_VP1, M_DA1, M_DB1, M_VA1, M_VB1: return 2'd1;
      M_SQ2, M_VP2, M_DA2, M_DB2, M_VA2, M_VB2: return 2'd2;
      default:                                  return 2'd0;
    endcase
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    if (v > 40'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -40'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

@@ hw/rtl/bpcr_ctrl.sv @@
// Controller: sequences accept, products, square root, divisions and delivery.
module bpcr_ctrl #(
  parameter int FRAC_BITS = bpcr_pkg::FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_slot,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  bpcr_pkg::sts_t  sts,
  output bpcr_pkg::cmd_t  cmd
);
  import bpcr_pkg::*;

  localparam int DW = 33 + FRAC_BITS;
  localparam int CW = $clog2(DW);

  typedef enum logic [9:0] {
    S_IDLE      = 10'b0000000001,
    S_MUL1      = 10'b0000000010,
    S_CHECK     = 10'b0000000100,
    S_SQRT      = 10'b0000001000,
    S_DIV_INIT  = 10'b0000010000,
    S_DIV_RUN   = 10'b0000100000,
    S_DIV_STORE = 10'b0001000000,
    S_MUL2      = 10'b0010000000,
    S_OUT_A     = 10'b0100000000,
    S_OUT_B     = 10'b1000000000
  } state_t;

  state_t         state_r, state_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  mop_t           mop_r, mop_nxt;
  dsel_t          dsel_r, dsel_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      mop_r   <= M_SQ0;
      dsel_r  <= D_N0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      mop_r   <= mop_nxt;
      dsel_r  <= dsel_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    mop_nxt    = mop_r;
    dsel_nxt   = dsel_r;
    cmd.op     = C_NONE;
    cmd.mop    = mop_r;
    cmd.dsel   = dsel_r;
    cmd.show_b = (state_r == S_OUT_B);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_slot) begin
            cmd.op    = C_LOAD_B;
            mop_nxt   = M_SQ0;
            state_nxt = S_MUL1;
          end else begin
            cmd.op = C_STORE_A;
          end
        end
      end
      S_MUL1: begin
        cmd.op = C_MUL;
        if (mop_r == M_RSQ) begin
          state_nxt = S_CHECK;
        end else begin
          mop_nxt = mop_t'(5'(mop_r) + 5'd1);
        end
      end
      S_CHECK: begin
        cmd.op  = C_CHECK;
        cnt_nxt = '0;
        if (sts.outcome == ST_RESOLVED) begin
          state_nxt = S_SQRT;
        end else begin
          state_nxt = S_OUT_A;
        end
      end
      S_SQRT: begin
        cmd.op = C_SQRT;
        if (cnt_r == CW'(SQRT_STEPS - 1)) begin
          cnt_nxt   = '0;
          dsel_nxt  = D_N0;
          state_nxt = S_DIV_INIT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DIV_INIT: begin
        cmd.op    = C_DIV_INIT;
        cnt_nxt   = '0;
        state_nxt = S_DIV_RUN;
      end
      S_DIV_RUN: begin
        cmd.op = C_DIV_STEP;
        if (cnt_r == CW'(DW - 1)) begin
          state_nxt = S_DIV_STORE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DIV_STORE: begin
        cmd.op = C_DIV_STORE;
        if (dsel_r == D_CB) begin
          mop_nxt   = M_KA;
          state_nxt = S_MUL2;
        end else begin
          dsel_nxt  = dsel_t'(3'(dsel_r) + 3'd1);
          state_nxt = S_DIV_INIT;
        end
      end
      S_MUL2: begin
        cmd.op = C_MUL;
        if (mop_r == M_VB2) begin
          state_nxt = S_OUT_A;
        end else begin
          mop_nxt = mop_t'(5'(mop_r) + 5'd1);
        end
      end
      S_OUT_A: begin
        if (!out_stall) begin
          state_nxt = S_OUT_B;
        end
      end
      S_OUT_B: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT_A) || (state_r == S_OUT_B);

endmodule

@@ hw/rtl/bpcr_datapath.sv @@
// Datapath: held ball, shared multiplier, square root and divider, result registers.
module bpcr_datapath #(
  parameter int FRAC_BITS = bpcr_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bpcr_pkg::cmd_t      cmd,
  output bpcr_pkg::sts_t      sts,
  input  logic [16:0]         rebound,
  input  logic signed [31:0]  in_position_x,
  input  logic signed [31:0]  in_position_y,
  input  logic signed [31:0]  in_position_z,
  input  logic signed [31:0]  in_velocity_x,
  input  logic signed [31:0]  in_velocity_y,
  input  logic signed [31:0]  in_velocity_z,
  input  logic [30:0]         in_radius,
  input  logic [30:0]         in_inverse_mass,
  output logic signed [31:0]  out_new_position_x,
  output logic signed [31:0]  out_new_position_y,
  output logic signed [31:0]  out_new_position_z,
  output logic signed [31:0]  out_new_velocity_x,
  output logic signed [31:0]  out_new_velocity_y,
  output logic signed [31:0]  out_new_velocity_z,
  output logic [1:0]          out_contact_status
);
  import bpcr_pkg::*;

  localparam int DW   = 33 + FRAC_BITS;
  localparam int NW   = FRAC_BITS + 1;
  localparam int CAW  = FRAC_BITS + 2;
  localparam int AW   = 36 + FRAC_BITS;

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  // held ball A
  logic signed [31:0] held_p_r [3];
  logic signed [31:0] held_v_r [3];
  logic [30:0]        held_r_r;
  logic [30:0]        held_im_r;

  // pair working state
  logic signed [32:0] g_r    [3];
  logic signed [32:0] dvel_r [3];
  logic [31:0]        rsum_r, isum_r;
  logic               fixed_r;
  logic [30:0]        ib_r;
  logic signed [31:0] res_pa_r [3];
  logic signed [31:0] res_va_r [3];
  logic signed [31:0] res_pb_r [3];
  logic signed [31:0] res_vb_r [3];
  logic [65:0]        s_r;
  logic [63:0]        q_r;
  logic [63:0]        rad_r;
  logic [34:0]        srem_r;
  logic [31:0]        root_r;
  logic [DW-1:0]      dvd_r;
  logic [31:0]        drem_r;
  logic [NW-1:0]      nmag_r [3];
  logic [CAW-1:0]     ca_r, cb_r;
  logic signed [AW-1:0] acc_r;
  logic [33:0]        sa_r, sb_r;
  logic [35:0]        wa_r, wb_r;
  logic [1:0]         status_r;

  logic signed [31:0] in_p [3];
  logic signed [31:0] in_v [3];
  assign in_p[0] = in_position_x;
  assign in_p[1] = in_position_y;
  assign in_p[2] = in_position_z;
  assign in_v[0] = in_velocity_x;
  assign in_v[1] = in_velocity_y;
  assign in_v[2] = in_velocity_z;

  // shared operands
  logic [1:0]          ax;
  logic [32:0]         gmag, dmag;
  logic                gneg, dneg;
  logic                vneg;
  logic [AW-1:0]       amag;
  logic [33:0]         vmag;
  logic [31:0]         pen;
  logic [17:0]         kfac;
  logic [35:0]         a_op;
  logic [32:0]         b_op;
  logic [68:0]         prod;
  logic signed [AW-1:0] pext;
  logic signed [39:0]  delta, sd_pos, sd_vel;

  assign ax    = mop_axis(cmd.mop);
  assign gmag  = mag33(g_r[ax]);
  assign gneg  = g_r[ax][32];
  assign dmag  = mag33(dvel_r[ax]);
  assign dneg  = dvel_r[ax][32];
  assign vneg  = acc_r[AW-1];
  assign amag  = vneg ? AW'(-acc_r) : AW'(acc_r);
  assign vmag  = amag[FRAC_BITS +: 34];
  assign pen   = rsum_r - root_r;
  assign kfac  = 18'd65536 + 18'(rebound);

  always_comb begin
    a_op = '0;
    b_op = '0;
    case (cmd.mop)
      M_SQ0, M_SQ1, M_SQ2: begin
        a_op = 36'(gmag);
        b_op = gmag;
      end
      M_RSQ: begin
        a_op = 36'(rsum_r);
        b_op = 33'(rsum_r);
      end
      M_KA: begin
        a_op = 36'(ca_r);
        b_op = 33'(kfac);
      end
      M_KB: begin
        a_op = 36'(cb_r);
        b_op = 33'(kfac);
      end
      M_VP0, M_VP1, M_VP2: begin
        a_op = 36'(dmag);
        b_op = 33'(nmag_r[ax]);
      end
      M_SA: begin
        a_op = 36'(pen);
        b_op = 33'(ca_r);
      end
      M_SB: begin
        a_op = 36'(pen);
        b_op = 33'(cb_r);
      end
      M_WA: begin
        a_op = 36'(vmag);
        b_op = 33'(ca_r);
      end
      M_WB: begin
        a_op = 36'(vmag);
        b_op = 33'(cb_r);
      end
      M_DA0, M_DA1, M_DA2: begin
        a_op = 36'(sa_r);
        b_op = 33'(nmag_r[ax]);
      end
      M_DB0, M_DB1, M_DB2: begin
        a_op = 36'(sb_r);
        b_op = 33'(nmag_r[ax]);
      end
      M_VA0, M_VA1, M_VA2: begin
        a_op = wa_r;
        b_op = 33'(nmag_r[ax]);
      end
      M_VB0, M_VB1, M_VB2: begin
        a_op = wb_r;
        b_op = 33'(nmag_r[ax]);
      end
      default: begin
        a_op = '0;
        b_op = '0;
      end
    endcase
  end

  assign prod   = 69'(a_op) * 69'(b_op);
  assign pext   = signed'(AW'(prod));
  assign delta  = signed'({3'b000, prod[FRAC_BITS +: 37]});
  assign sd_pos = gneg ? -delta : delta;
  assign sd_vel = (gneg ^ vneg) ? -delta : delta;

  // contact outcome from the fixed flag, the squared gap and squared radius sum
  always_comb begin
    if (fixed_r) begin
      sts.outcome = ST_FIXED;
    end else if (s_r > {2'b00, q_r}) begin
      sts.outcome = ST_APART;
    end else if (s_r == '0) begin
      sts.outcome = ST_COINCIDENT;
    end else begin
      sts.outcome = ST_RESOLVED;
    end
  end

  // square root step
  logic [34:0] sq_sh, sq_trial;
  logic        sq_ge;
  assign sq_sh    = {srem_r[32:0], rad_r[63:62]};
  assign sq_trial = {1'b0, root_r, 2'b01};
  assign sq_ge    = (sq_sh >= sq_trial);

  // divider step
  logic [31:0] dvsr;
  logic [32:0] dv_sh, dv_diff;
  logic        dv_ge;
  logic [DW-1:0] dividend;
  assign dvsr    = (cmd.dsel == D_CA || cmd.dsel == D_CB) ? isum_r : root_r;
  assign dv_sh   = {drem_r, dvd_r[DW-1]};
  assign dv_diff = dv_sh - {1'b0, dvsr};
  assign dv_ge   = (dv_sh >= {1'b0, dvsr});

  always_comb begin
    case (cmd.dsel)
      D_N0:    dividend = {mag33(g_r[0]), {FRAC_BITS{1'b0}}};
      D_N1:    dividend = {mag33(g_r[1]), {FRAC_BITS{1'b0}}};
      D_N2:    dividend = {mag33(g_r[2]), {FRAC_BITS{1'b0}}};
      D_CA:    dividend = {2'b00, held_im_r, {FRAC_BITS{1'b0}}};
      D_CB:    dividend = {2'b00, ib_r, {FRAC_BITS{1'b0}}};
      default: dividend = '0;
    endcase
  end

  // held ball A is architectural state: cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        held_p_r[i] <= '0;
        held_v_r[i] <= '0;
      end
      held_r_r  <= '0;
      held_im_r <= '0;
    end else if (cmd.op == C_STORE_A) begin
      for (int i = 0; i < 3; i++) begin
        held_p_r[i] <= in_p[i];
        held_v_r[i] <= in_v[i];
      end
      held_r_r  <= in_radius;
      held_im_r <= in_inverse_mass;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      C_LOAD_B: begin
        for (int i = 0; i < 3; i++) begin
          g_r[i]      <= 33'(in_p[i]) - 33'(held_p_r[i]);
          dvel_r[i]   <= 33'(held_v_r[i]) - 33'(in_v[i]);
          res_pa_r[i] <= held_p_r[i];
          res_va_r[i] <= held_v_r[i];
          res_pb_r[i] <= in_p[i];
          res_vb_r[i] <= in_v[i];
        end
        rsum_r  <= 32'(held_r_r) + 32'(in_radius);
        isum_r  <= 32'(held_im_r) + 32'(in_inverse_mass);
        ib_r    <= in_inverse_mass;
        fixed_r <= (held_im_r == '0) && (in_inverse_mass == '0);
        s_r     <= '0;
        acc_r   <= '0;
      end
      C_MUL: begin
        case (cmd.mop)
          M_SQ0, M_SQ1, M_SQ2: s_r <= s_r + 66'(prod);
          M_RSQ:               q_r <= prod[63:0];
          M_KA:                ca_r <= prod[16 +: CAW];
          M_KB:                cb_r <= prod[16 +: CAW];
          M_VP0, M_VP1, M_VP2: acc_r <= (dneg ^ gneg) ? acc_r - pext : acc_r + pext;
          M_SA:                sa_r <= prod[FRAC_BITS +: 34];
          M_SB:                sb_r <= prod[FRAC_BITS +: 34];
          M_WA:                wa_r <= prod[FRAC_BITS +: 36];
          M_WB:                wb_r <= prod[FRAC_BITS +: 36];
          M_DA0, M_DA1, M_DA2: res_pa_r[ax] <= sat32(40'(res_pa_r[ax]) - sd_pos);
          M_DB0, M_DB1, M_DB2: res_pb_r[ax] <= sat32(40'(res_pb_r[ax]) + sd_pos);
          M_VA0, M_VA1, M_VA2: res_va_r[ax] <= sat32(40'(res_va_r[ax]) - sd_vel);
          M_VB0, M_VB1, M_VB2: res_vb_r[ax] <= sat32(40'(res_vb_r[ax]) + sd_vel);
          default: begin
          end
        endcase
      end
      C_CHECK: begin
        status_r <= sts.outcome;
        rad_r    <= s_r[63:0];
        srem_r   <= '0;
        root_r   <= '0;
      end
      C_SQRT: begin
        srem_r <= sq_ge ? (sq_sh - sq_trial) : sq_sh;
        root_r <= {root_r[30:0], sq_ge};
        rad_r  <= {rad_r[61:0], 2'b00};
      end
      C_DIV_INIT: begin
        dvd_r  <= dividend;
        drem_r <= '0;
      end
      C_DIV_STEP: begin
        drem_r <= dv_ge ? dv_diff[31:0] : dv_sh[31:0];
        dvd_r  <= {dvd_r[DW-2:0], dv_ge};
      end
      C_DIV_STORE: begin
        case (cmd.dsel)
          D_N0:    nmag_r[0] <= dvd_r[NW-1:0];
          D_N1:    nmag_r[1] <= dvd_r[NW-1:0];
          D_N2:    nmag_r[2] <= dvd_r[NW-1:0];
          D_CA:    ca_r <= CAW'(dvd_r[NW-1:0]);
          D_CB:    cb_r <= CAW'(dvd_r[NW-1:0]);
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  assign out_new_position_x = cmd.show_b ? res_pb_r[0] : res_pa_r[0];
  assign out_new_position_y = cmd.show_b ? res_pb_r[1] : res_pa_r[1];
  assign out_new_position_z = cmd.show_b ? res_pb_r[2] : res_pa_r[2];
  assign out_new_velocity_x = cmd.show_b ? res_vb_r[0] : res_va_r[0];
  assign out_new_velocity_y = cmd.show_b ? res_vb_r[1] : res_va_r[1];
  assign out_new_velocity_z = cmd.show_b ? res_vb_r[2] : res_va_r[2];
  assign out_contact_status = status_r;

endmodule

@@ hw/rtl/ball_pair_collision_response_top.sv @@
// Top level: ball pair collision response with its configuration register.
//
// Usage: balls enter one transaction at a time on the in_ channel. A transaction
// with in_slot 0 stores ball A and produces nothing. A transaction with in_slot 1
// carries ball B; the block resolves the contact against the stored A and
// delivers two out_ transactions, A first (out_which_ball 0), then B
// (out_which_ball 1, out_last_of_pair 1), both with the same contact status.
// Sequence: storing A leaves the block idle. Every pair takes four squares and
// the contact check. A pair with no contact, both balls fixed or coincident
// centres then goes straight to delivery. A resolved pair first runs a 32-step
// square root, five restoring divisions of 33 + FRAC_BITS steps each on one
// shared divider, and 21 products on one shared multiplier.
// Reset (rst_n low, synchronous) clears the stored ball to zero, sets rebound to
// one half and returns the sequencer to idle; no clearing pass is needed.
// While the receiver stalls, the current result holds; in_stall stays high from
// the accepted B transaction until the B result has been taken.
// rebound lives at byte address 0 of the APB-style cfg_ port; write it only when idle.
`include "ball_pair_collision_response_top_assert.svh"

module ball_pair_collision_response_top #(
  parameter int FRAC_BITS = bpcr_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_slot,
  input  logic signed [31:0] in_position_x,
  input  logic signed [31:0] in_position_y,
  input  logic signed [31:0] in_position_z,
  input  logic signed [31:0] in_velocity_x,
  input  logic signed [31:0] in_velocity_y,
  input  logic signed [31:0] in_velocity_z,
  input  logic [30:0]        in_radius,
  input  logic [30:0]        in_inverse_mass,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_which_ball,
  output logic signed [31:0] out_new_position_x,
  output logic signed [31:0] out_new_position_y,
  output logic signed [31:0] out_new_position_z,
  output logic signed [31:0] out_new_velocity_x,
  output logic signed [31:0] out_new_velocity_y,
  output logic signed [31:0] out_new_velocity_z,
  output logic [1:0]         out_contact_status,
  output logic               out_last_of_pair,
  // configuration port
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  import bpcr_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  logic [16:0] rebound_r;
  logic        cfg_wr;

  // Write the register on the access phase; the word index is paddr[2].
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rebound_r <= REBOUND_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == REG_REBOUND)) begin
      rebound_r <= cfg_pwdata[16:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_REBOUND) ? 32'(rebound_r) : '0;

  // Controller walks the sequence; datapath holds the ball, working and result values.
  bpcr_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_slot   (in_slot),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  bpcr_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .rebound            (rebound_r),
    .in_position_x      (in_position_x),
    .in_position_y      (in_position_y),
    .in_position_z      (in_position_z),
    .in_velocity_x      (in_velocity_x),
    .in_velocity_y      (in_velocity_y),
    .in_velocity_z      (in_velocity_z),
    .in_radius          (in_radius),
    .in_inverse_mass    (in_inverse_mass),
    .out_new_position_x (out_new_position_x),
    .out_new_position_y (out_new_position_y),
    .out_new_position_z (out_new_position_z),
    .out_new_velocity_x (out_new_velocity_x),
    .out_new_velocity_y (out_new_velocity_y),
    .out_new_velocity_z (out_new_velocity_z),
    .out_contact_status (out_contact_status)
  );

  // The B result is the second of the pair.
  assign out_which_ball   = cmd.show_b;
  assign out_last_of_pair = cmd.show_b;

  // No input is taken while a pair is being delivered.
  `BPCR_ASSERT_SAME(a_busy_while_out, out_valid, in_stall)
  // Taking the A result is followed at once by the B result.
  `BPCR_ASSERT_NEXT(a_b_follows_a, out_valid && !out_stall && !out_which_ball,
                    out_valid && out_which_ball)
  // A B transaction starts the sequence and blocks further input.
  `BPCR_ASSERT_NEXT(a_busy_after_b, in_valid && !in_stall && in_slot, in_stall)

endmodule
